>>> hdl/fcv_pkg.sv
// Package for the FIR convolver: field widths, stream widths, register
// indexes and the control struct handed from the sequencer to the tap cells.
// No dependencies.
package fcv_pkg;

  localparam int DATA_W       = 24;
  localparam int IDX_W        = 5;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int SUM_W        = 54;
  localparam int KLEN_W       = 6;
  localparam int SEEN_W       = 6;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 56;
  localparam int MAX_TAPS_DEF = 32;

  localparam logic       KIND_TAP      = 1'b0;
  localparam logic       KIND_SAMPLE   = 1'b1;
  localparam logic       REG_CENTERED  = 1'b0;
  localparam logic       REG_KLEN      = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> hdl/fir_convolver_same_or_full_core.sv
// FIR convolver top level: sequencer, configuration registers, output
// register and the chain of fcv_cell tap cells. Depends on fcv_pkg, fcv_cell.
//
// Usage: items arrive on the s_ stream. s_tuser is the kind (0 tap write,
// 1 signal sample), s_tdata holds tap_index and sample_value, s_tlast marks
// the last sample of a signal. Tap writes complete in the transfer cycle and
// give no result. Each sample shifts into the delay line; its sum runs through
// the partial-sum chain of MAX_TAPS cells, and the next item can transfer
// only after that pass. After the last sample the block shifts in zeros for
// the tail (K-1 in full mode, floor((K-1)/2) in centered mode), then clears
// the delay line. One item is worked on at a time; s_tready is high only
// while the block is between items. Results leave on the m_ stream through
// a single output register: m_tdata holds sum_value, m_tlast marks the final
// result of the signal. A stalled receiver holds the result and the sequencer
// waits before loading the next one. Reset (rst, synchronous) clears taps,
// delay line, sample count and sets centered mode, K = 1. Configuration is
// written through cfg_we/cfg_index/cfg_data while idle; the user must keep
// to this, as the block itself does not enforce it.
module fir_convolver_same_or_full_core
  import fcv_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,   // tap_index[4:0], sample_value[28:5]
  input  logic                    s_tuser,   // kind
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata,   // sum_value[53:0]
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [KLEN_W-1:0]       cfg_data
);

  localparam int K_W   = $clog2(MAX_TAPS + 1);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int CW    = 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [K_W-1:0]    fidx;
  logic              flushing;
  logic              last_q;
  logic              emit_q;
  logic              eos_q;
  logic [SEEN_W-1:0] seen;
  logic              centered_mode;
  logic [KLEN_W-1:0] kernel_length;

  logic [IDX_W-1:0]         tap_index;
  logic signed [DATA_W-1:0] sample_value;
  logic [6:0]               kl7;
  logic [6:0]               k7;
  logic [K_W-1:0]           k_eff;
  logic [K_W-1:0]           c_off;
  logic [K_W-1:0]           f_cnt;
  logic [K_W-1:0]           next_m;
  logic [SEEN_W-1:0]        seen_inc;
  logic                     take;
  logic                     take_sample;
  logic                     emit_go;
  logic                     load;
  logic                     more;
  logic                     shift_zero;
  cell_ctl_t                ctl;

  logic signed [DATA_W-1:0] x_chain [MAX_TAPS+1];
  logic signed [SUM_W-1:0]  s_chain [MAX_TAPS+1];

  assign tap_index    = s_tdata[IDX_W-1:0];
  assign sample_value = s_tdata[IDX_W+DATA_W-1:IDX_W];

  assign kl7   = {1'b0, kernel_length};
  assign k7    = (kl7 == 7'd0) ? 7'd1 : ((kl7 > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : kl7);
  assign k_eff = k7[K_W-1:0];
  assign c_off = centered_mode ? ((k_eff - K_W'(1)) >> 1) : '0;
  assign f_cnt = centered_mode ? c_off : (k_eff - K_W'(1));

  assign seen_inc = (seen == {SEEN_W{1'b1}}) ? seen : (seen + SEEN_W'(1));

  assign s_tready    = (state == ST_IDLE);
  assign take        = s_tvalid && s_tready;
  assign take_sample = take && (s_tuser == KIND_SAMPLE);

  assign emit_go = (state == ST_EMIT) && (!emit_q || !m_tvalid || m_tready);
  assign load    = emit_go && emit_q;
  assign next_m  = flushing ? (fidx + K_W'(1)) : '0;
  assign more    = last_q && (next_m < f_cnt);

  assign shift_zero = emit_go && more;
  assign ctl.shift  = take_sample || shift_zero;
  assign ctl.clear  = emit_go && !more && last_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      centered_mode <= 1'b1;
      kernel_length <= KLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTERED: centered_mode <= cfg_data[0];
        REG_KLEN:     kernel_length <= cfg_data;
        default:      ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      fidx     <= '0;
      flushing <= 1'b0;
      last_q   <= 1'b0;
      emit_q   <= 1'b0;
      eos_q    <= 1'b0;
      seen     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take_sample) begin
            emit_q   <= (CW'(seen) >= CW'(c_off));
            eos_q    <= s_tlast && (f_cnt == '0);
            last_q   <= s_tlast;
            flushing <= 1'b0;
            seen     <= seen_inc;
            cnt      <= '0;
            state    <= ST_SUM;
          end
        end
        ST_SUM: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_TAPS)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (more) begin
              fidx     <= next_m;
              flushing <= 1'b1;
              emit_q   <= !centered_mode || (CW'(seen) + CW'(next_m) >= CW'(c_off));
              eos_q    <= (next_m == f_cnt - K_W'(1));
              cnt      <= '0;
              state    <= ST_SUM;
            end else begin
              if (last_q) begin
                seen <= '0;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(OUT_TDATA_W - SUM_W){1'b0}}, s_chain[MAX_TAPS]};
      m_tlast <= eos_q;
    end
  end

  assign x_chain[0] = shift_zero ? '0 : sample_value;
  assign s_chain[0] = '0;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic tap_we;
    logic active;

    assign tap_we = take && (s_tuser == KIND_TAP) && ({2'b00, tap_index} == 7'(i));
    assign active = (7'(i) < k7);

    fcv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .tap_we   (tap_we),
      .tap_in   (sample_value),
      .x_in     (x_chain[i]),
      .active   (active),
      .psum_in  (s_chain[i]),
      .x_out    (x_chain[i+1]),
      .psum_out (s_chain[i+1])
    );
  end

  a_clear_empties_line: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (x_chain[1] == '0))
    else $error("delay line not cleared after end of signal");

  a_final_result_ends: assert property (@(posedge clk) disable iff (rst)
    (load && eos_q) |=> (state == ST_IDLE) && (seen == '0))
    else $error("final result loaded but signal not closed");

  a_sum_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (cnt <= CNT_W'(MAX_TAPS)))
    else $error("sum pass counter overran the chain length");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !ctl.shift || shift_zero)
    else $error("sample shifted while a sum pass is in progress");

endmodule

>>> hdl/fcv_cell.sv
// One tap cell of the convolver chain: coefficient, delay stage, product
// and running partial sum handed to the next cell every cycle.
// Depends on fcv_pkg.
module fcv_cell
  import fcv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctl_t                ctl,
  input  logic                     tap_we,
  input  logic signed [DATA_W-1:0] tap_in,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic                     active,
  input  logic signed [SUM_W-1:0]  psum_in,
  output logic signed [DATA_W-1:0] x_out,
  output logic signed [SUM_W-1:0]  psum_out
);

  logic signed [DATA_W-1:0] tap;
  logic signed [DATA_W-1:0] delay;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  psum;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap   <= '0;
      delay <= '0;
    end else begin
      if (tap_we) begin
        tap <= tap_in;
      end
      if (ctl.clear) begin
        delay <= '0;
      end else if (ctl.shift) begin
        delay <= x_in;
      end
    end
  end

  assign prod_ext = active ? {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod} : '0;

  always_ff @(posedge clk) begin
    prod <= tap * delay;
    psum <= psum_in + prod_ext;
  end

  assign x_out    = delay;
  assign psum_out = psum;

endmodule
